/* rtl/ntcadc_pkg.sv */
`default_nettype none
package ntcadc_pkg;

   localparam int ADC_BITS      = 12;
   localparam int TABLE_ENTRIES = 141;

   localparam int ROM_SIZE     = 141;
   localparam int ROM_W        = 18;
   localparam int USED_ENTRIES = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
   localparam int IDX_W        = 8;
   localparam int FIRST_DEGREE = 30;

   // code * 10^6 needs 20 more bits than the code, 100 * (2^ADC_BITS - code) 7 more
   localparam int NUM_W   = ADC_BITS + 20;
   localparam int DEN_W   = ADC_BITS + 7;
   localparam int RES_W   = ADC_BITS + 14;
   localparam int CNT_W   = $clog2(NUM_W);
   localparam int TEMP_W  = 16;
   localparam int FRAC_W  = 8;
   localparam int OHMS_W  = 26;

   localparam logic [31:0] OHMS_MAX = 32'h03FF_FFFF;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USED_ENTRIES - 2);

   localparam logic [ROM_W-1:0] RES_ROM [ROM_SIZE] = '{
      18'd149240, 18'd140710, 18'd132740, 18'd125270, 18'd118270,
      18'd111710, 18'd105560, 18'd99788,  18'd94372,  18'd89285,
      18'd84507,  18'd80015,  18'd75791,  18'd71818,  18'd68079,
      18'd64558,  18'd61242,  18'd58117,  18'd55172,  18'd52394,
      18'd49773,  18'd47299,  18'd44964,  18'd42759,  18'd40675,
      18'd38705,  18'd36843,  18'd35081,  18'd33414,  18'd31837,
      18'd30343,  18'd28928,  18'd27587,  18'd26317,  18'd25112,
      18'd23970,  18'd22886,  18'd21857,  18'd20881,  18'd19954,
      18'd19073,  18'd18236,  18'd17440,  18'd16684,  18'd15965,
      18'd15281,  18'd14630,  18'd14010,  18'd13420,  18'd12858,
      18'd12323,  18'd11327,  18'd11327,  18'd10864,  18'd10422,
      18'd10000,  18'd9598,   18'd9214,   18'd8847,   18'd8498,
      18'd8163,   18'd7840,   18'd7539,   18'd7247,   18'd6969,
      18'd6702,   18'd6447,   18'd6203,   18'd5970,   18'd5746,
      18'd5532,   18'd5328,   18'd5131,   18'd4943,   18'd4763,
      18'd4591,   18'd4425,   18'd4267,   18'd4115,   18'd3969,
      18'd3829,   18'd3694,   18'd3565,   18'd3442,   18'd3323,
      18'd3209,   18'd3099,   18'd2994,   18'd2892,   18'd2795,
      18'd2701,   18'd2611,   18'd2525,   18'd2442,   18'd2362,
      18'd2285,   18'd2210,   18'd2139,   18'd2070,   18'd2004,
      18'd1940,   18'd1879,   18'd1820,   18'd1763,   18'd1708,
      18'd1655,   18'd1604,   18'd1555,   18'd1507,   18'd1461,
      18'd1417,   18'd1374,   18'd1333,   18'd1294,   18'd1255,
      18'd1218,   18'd1182,   18'd1148,   18'd1115,   18'd1082,
      18'd1051,   18'd1021,   18'd992,    18'd964,    18'd937,
      18'd910,    18'd885,    18'd860,    18'd836,    18'd813,
      18'd791,    18'd769,    18'd749,    18'd728,    18'd709,
      18'd690,    18'd671,    18'd654,    18'd636,    18'd620,
      18'd603
   };

   function automatic logic [ROM_W-1:0] rom_entry(input logic [IDX_W-1:0] a);
      logic [ROM_W-1:0] v;
      v = '0;
      if (int'(a) < ROM_SIZE) begin
         v = RES_ROM[a];
      end
      return v;
   endfunction

endpackage
`default_nettype wire

/* rtl/ntc_adc_to_temperature_unit.sv */
`default_nettype none
// Thermistor ADC code to temperature.
//
// req_ channel: one adc_code word, taken when req_valid is high and req_stall
// low. req_stall is high from acceptance until the result has been written to
// the output register, so one word is in work at a time.
// rsp_ channel: temp_q8 (signed, 8 fraction bits), resistance_ohms and
// in_range, held in an output register until taken (rsp_valid high, rsp_stall
// low). A new word is accepted while a finished result still waits there.
// Sequence from the accepting edge (which loads the divider) to rsp_valid:
// 32 steps of the shared restoring divider for the resistance, a table
// walk of up to 140 intervals (one interval a cycle), 32 more divider steps
// for the interpolation fraction when the value lies in the table, and the
// write of the output register once it is free; the time taken is set by
// the single divider and the linear walk of the resistance table.
// The next word is taken only after the result is in the output register.
// When rsp_stall holds the previous result, the new result waits in the unit
// and req_stall stays high.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_valid; no stores need clearing.
module ntc_adc_to_temperature_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [ntcadc_pkg::ADC_BITS-1:0]         req_adc_code,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [ntcadc_pkg::TEMP_W-1:0]         rsp_temp_q8,
   output logic [ntcadc_pkg::OHMS_W-1:0]                rsp_resistance_ohms,
   output logic                                         rsp_in_range
);
   import ntcadc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_RES,
      ST_SEARCH,
      ST_DIV_FRAC,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [NUM_W-1:0]      num_ff;   // dividend bits out at the top, quotient bits in below
   logic [DEN_W-1:0]      den_ff;
   logic [DEN_W-1:0]      rem_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [RES_W-1:0]      res_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [FRAC_W-1:0]     frac_ff;
   logic                  ok_ff;
   logic                  rsp_valid_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic [OHMS_W-1:0]     rsp_ohms_ff;
   logic                  rsp_ok_ff;

   // shared divider step
   logic [DEN_W:0]        rem_sh;
   logic [DEN_W:0]        diff;
   logic                  q_bit;
   logic [DEN_W-1:0]      rem_in;
   logic [NUM_W-1:0]      num_in;
   logic                  div_last;

   always_comb begin
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      diff     = rem_sh - {1'b0, den_ff};
      q_bit    = ~diff[DEN_W];
      rem_in   = q_bit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_in   = {num_ff[NUM_W-2:0], q_bit};
      div_last = (cnt_ff == CNT_W'(NUM_W - 1));
   end

   // table interval under test
   logic [ROM_W-1:0]      tab_hi;
   logic [ROM_W-1:0]      tab_lo;
   logic                  hit;

   always_comb begin
      tab_hi = rom_entry(idx_ff);
      tab_lo = rom_entry(idx_ff + IDX_W'(1));
      hit    = (res_ff <= RES_W'(tab_hi)) && (res_ff > RES_W'(tab_lo));
   end

   // load values for a new word
   logic [ADC_BITS:0]     span;
   logic                  out_free;
   logic                  ohms_sat;

   always_comb begin
      span     = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, req_adc_code};
      out_free = ~rsp_valid_ff | ~rsp_stall;
      ohms_sat = (32'(res_ff) > OHMS_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished result, else drop a taken one
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  num_ff   <= NUM_W'(req_adc_code) * NUM_W'(1000000);
                  den_ff   <= DEN_W'(span) * DEN_W'(100);
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV_RES;
               end
            end
            ST_DIV_RES: begin
               num_ff <= num_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (div_last) begin
                  res_ff   <= num_in[RES_W-1:0];
                  idx_ff   <= '0;
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (hit) begin
                  // fraction = (hi - r) * 256 / (hi - lo), always below 256
                  num_ff   <= NUM_W'({tab_hi - res_ff[ROM_W-1:0], {FRAC_W{1'b0}}});
                  den_ff   <= DEN_W'(tab_hi - tab_lo);
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV_FRAC;
               end else if (idx_ff == LAST_IDX) begin
                  ok_ff    <= 1'b0;
                  frac_ff  <= '0;
                  state_ff <= ST_FINISH;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            ST_DIV_FRAC: begin
               num_ff <= num_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (div_last) begin
                  frac_ff  <= num_in[FRAC_W-1:0];
                  ok_ff    <= 1'b1;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_ok_ff    <= ok_ff;
                  rsp_ohms_ff  <= ohms_sat ? {OHMS_W{1'b1}} : OHMS_W'(res_ff);
                  rsp_temp_ff  <= ok_ff ?
                     signed'({IDX_W'(idx_ff - IDX_W'(FIRST_DEGREE)), frac_ff}) :
                     '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_temp_q8         = rsp_temp_ff;
   assign rsp_resistance_ohms = rsp_ohms_ff;
   assign rsp_in_range        = rsp_ok_ff;

endmodule
`default_nettype wire
